// ===== sv/ctp_pkg.sv =====
// Shared types, constants and saturating helpers for the cons-to-prim pipeline.
package ctp_pkg;

  localparam int WIDTH         = 48;
  localparam int CFG_WIDTH     = 47;
  localparam int FRAC_BITS_DEF = 24;
  localparam int MUL_LAT       = 4;
  localparam int ADDR_WIDTH    = 4;
  localparam int DATA_WIDTH    = 64;

  localparam logic [CFG_WIDTH-1:0] GAS_CONSTANT_RST    = 47'd16777216;
  localparam logic [CFG_WIDTH-1:0] GAMMA_MINUS_ONE_RST = 47'd6710886;

  localparam logic [WIDTH-1:0] MAG_POS_LIM = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] MAG_NEG_LIM = {1'b1, {(WIDTH-1){1'b0}}};

  typedef enum logic {
    REG_GAS_CONSTANT    = 1'b0,
    REG_GAMMA_MINUS_ONE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] gas_constant;
    logic [CFG_WIDTH-1:0] gamma_minus_one;
  } cfg_t;

  function automatic logic [WIDTH-1:0] mag(input logic signed [WIDTH-1:0] a);
    mag = a[WIDTH-1] ? WIDTH'(-a) : WIDTH'(a);
  endfunction

  function automatic logic signed [WIDTH-1:0] sat(input logic signed [WIDTH:0] s);
    if (s[WIDTH] != s[WIDTH-1]) begin
      sat = s[WIDTH] ? $signed(MAG_NEG_LIM) : $signed(MAG_POS_LIM);
    end else begin
      sat = s[WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [WIDTH-1:0] qadd(input logic signed [WIDTH-1:0] a,
                                                   input logic signed [WIDTH-1:0] b);
    logic signed [WIDTH:0] s;
    s = {a[WIDTH-1], a} + {b[WIDTH-1], b};
    qadd = sat(s);
  endfunction

  function automatic logic signed [WIDTH-1:0] qsub(input logic signed [WIDTH-1:0] a,
                                                   input logic signed [WIDTH-1:0] b);
    logic signed [WIDTH:0] s;
    s = {a[WIDTH-1], a} - {b[WIDTH-1], b};
    qsub = sat(s);
  endfunction

  // Apply sign to a clamped magnitude.
  function automatic logic signed [WIDTH-1:0] signed_result(input logic [WIDTH-1:0] m,
                                                            input logic neg);
    logic [WIDTH-1:0] lim;
    logic [WIDTH-1:0] mc;
    lim = neg ? MAG_NEG_LIM : MAG_POS_LIM;
    mc  = (m > lim) ? lim : m;
    signed_result = neg ? -$signed(mc) : $signed(mc);
  endfunction

endpackage

// ===== sv/cons_to_prim_with_gradients_top.sv =====
// Ideal-gas conservative-to-primitive conversion with axis gradients.
// The start-to-done path runs through two divider passes in series (one quotient bit per
// stage) and three multipliers.
// Throughput: one beat per cycle; busy stays low.
// Reset clears the valid line and loads gas constant 1.0 and gamma minus one 0.4.
// Results appear on done for one cycle; the receiver cannot stall.
module cons_to_prim_with_gradients_top #(
  parameter int FRAC_BITS = ctp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ctp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [ctp_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [ctp_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [ctp_pkg::WIDTH-1:0] density,
  input  logic signed [ctp_pkg::WIDTH-1:0] momentum_x,
  input  logic signed [ctp_pkg::WIDTH-1:0] momentum_y,
  input  logic signed [ctp_pkg::WIDTH-1:0] momentum_z,
  input  logic signed [ctp_pkg::WIDTH-1:0] total_energy,
  input  logic signed [ctp_pkg::WIDTH-1:0] density_gradient,
  input  logic signed [ctp_pkg::WIDTH-1:0] momentum_x_gradient,
  input  logic signed [ctp_pkg::WIDTH-1:0] momentum_y_gradient,
  input  logic signed [ctp_pkg::WIDTH-1:0] momentum_z_gradient,
  input  logic signed [ctp_pkg::WIDTH-1:0] energy_gradient,
  input  logic                             last_point,
  output logic                             done,
  output logic signed [ctp_pkg::WIDTH-1:0] pressure,
  output logic signed [ctp_pkg::WIDTH-1:0] velocity_x,
  output logic signed [ctp_pkg::WIDTH-1:0] velocity_y,
  output logic signed [ctp_pkg::WIDTH-1:0] velocity_z,
  output logic signed [ctp_pkg::WIDTH-1:0] temperature,
  output logic signed [ctp_pkg::WIDTH-1:0] pressure_gradient,
  output logic signed [ctp_pkg::WIDTH-1:0] velocity_x_gradient,
  output logic signed [ctp_pkg::WIDTH-1:0] velocity_y_gradient,
  output logic signed [ctp_pkg::WIDTH-1:0] velocity_z_gradient,
  output logic signed [ctp_pkg::WIDTH-1:0] temperature_gradient,
  output logic                             bad_density,
  output logic                             last_point_out
);

  localparam int W   = ctp_pkg::WIDTH;
  localparam int LD  = W + FRAC_BITS + 2;
  localparam int LM  = ctp_pkg::MUL_LAT;
  localparam int TA  = LD;
  localparam int TB  = TA + LM;
  localparam int TC  = TB + 2;
  localparam int TD  = TC + 1;
  localparam int TE  = TD + LM;
  localparam int TF  = TE + 1;
  localparam int TG  = TF + LD;
  localparam int TH  = TG + LM;
  localparam int LAT = TH + 1;

  ctp_pkg::cfg_t cfg;
  logic signed [W-1:0] gas_r, gm1_r;

  ctp_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign gas_r = {1'b0, cfg.gas_constant};
  assign gm1_r = {1'b0, cfg.gamma_minus_one};
  assign busy  = 1'b0;

  // first divider bank: velocities, specific energy, 1/cv
  logic signed [W-1:0] u_a, v_a, w_a, e_a, ci_a;
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_u  (.clk, .a(momentum_x),   .b(density), .y(u_a));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_v  (.clk, .a(momentum_y),   .b(density), .y(v_a));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_w  (.clk, .a(momentum_z),   .b(density), .y(w_a));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_e  (.clk, .a(total_energy), .b(density), .y(e_a));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_ci (.clk, .a(gm1_r),        .b(gas_r),   .y(ci_a));

  logic signed [W-1:0] rr_m, rr_f;
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_rr (.clk, .a(gas_r), .b(density), .y(rr_m));
  ctp_delay #(.WIDTH(W), .DEPTH(LD + LM + 4)) u_dly_rr (.clk, .d(rr_m), .q(rr_f));

  logic signed [W-1:0] drho_a, dmx_a, dmy_a, dmz_a;
  ctp_delay #(.WIDTH(4*W), .DEPTH(TA)) u_dly_ga (
    .clk,
    .d({density_gradient, momentum_x_gradient, momentum_y_gradient, momentum_z_gradient}),
    .q({drho_a, dmx_a, dmy_a, dmz_a})
  );

  // products of velocities with themselves and with the gradients
  logic signed [W-1:0] uu, vv, ww, udx, vdy, wdz, udr, vdr, wdr;
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uu  (.clk, .a(u_a), .b(u_a),    .y(uu));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_vv  (.clk, .a(v_a), .b(v_a),    .y(vv));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ww  (.clk, .a(w_a), .b(w_a),    .y(ww));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_udx (.clk, .a(u_a), .b(dmx_a),  .y(udx));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_vdy (.clk, .a(v_a), .b(dmy_a),  .y(vdy));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_wdz (.clk, .a(w_a), .b(dmz_a),  .y(wdz));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_udr (.clk, .a(u_a), .b(drho_a), .y(udr));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_vdr (.clk, .a(v_a), .b(drho_a), .y(vdr));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_wdr (.clk, .a(w_a), .b(drho_a), .y(wdr));

  logic signed [W-1:0] dmx_b, dmy_b, dmz_b;
  ctp_delay #(.WIDTH(3*W), .DEPTH(TB)) u_dly_gb (
    .clk,
    .d({momentum_x_gradient, momentum_y_gradient, momentum_z_gradient}),
    .q({dmx_b, dmy_b, dmz_b})
  );

  logic signed [W-1:0] s1, ww_c, ud1, wdz_c, nx, ny, nz, v2, ud;
  always_ff @(posedge clk) begin
    s1    <= ctp_pkg::qadd(uu, vv);
    ww_c  <= ww;
    ud1   <= ctp_pkg::qadd(udx, vdy);
    wdz_c <= wdz;
    nx    <= ctp_pkg::qsub(dmx_b, udr);
    ny    <= ctp_pkg::qsub(dmy_b, vdr);
    nz    <= ctp_pkg::qsub(dmz_b, wdr);
    v2    <= ctp_pkg::qadd(s1, ww_c);
    ud    <= ctp_pkg::qadd(ud1, wdz_c);
  end

  // velocity gradients
  logic signed [W-1:0] rho_b, du_m, dv_m, dw_m, du_h, dv_h, dw_h;
  ctp_delay #(.WIDTH(W), .DEPTH(TB + 1)) u_dly_rb (.clk, .d(density), .q(rho_b));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_du (.clk, .a(nx), .b(rho_b), .y(du_m));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_dv (.clk, .a(ny), .b(rho_b), .y(dv_m));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_dw (.clk, .a(nz), .b(rho_b), .y(dw_m));
  ctp_delay #(.WIDTH(3*W), .DEPTH(2*LM + 3)) u_dly_dv (
    .clk, .d({du_m, dv_m, dw_m}), .q({du_h, dv_h, dw_h})
  );

  logic signed [W-1:0] e_c, den_c, hv2, ehv, vme, dmud;
  ctp_delay #(.WIDTH(W), .DEPTH(LM + 2)) u_dly_e  (.clk, .d(e_a), .q(e_c));
  ctp_delay #(.WIDTH(W), .DEPTH(TC))     u_dly_de (.clk, .d(energy_gradient), .q(den_c));

  always_ff @(posedge clk) begin
    hv2  <= v2 >>> 1;
    ehv  <= ctp_pkg::qsub(e_c, v2 >>> 1);
    vme  <= ctp_pkg::qsub(v2, e_c);
    dmud <= ctp_pkg::qsub(den_c, ud);
  end

  logic signed [W-1:0] drho_d, ci_d, ci_g;
  ctp_delay #(.WIDTH(W), .DEPTH(TD))          u_dly_rd (.clk, .d(density_gradient), .q(drho_d));
  ctp_delay #(.WIDTH(W), .DEPTH(LM + 3))      u_dly_cd (.clk, .d(ci_a), .q(ci_d));
  ctp_delay #(.WIDTH(W), .DEPTH(LD + LM + 1)) u_dly_cg (.clk, .d(ci_d), .q(ci_g));

  logic signed [W-1:0] t_e, a_e, b_e, dmud_e;
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_t (.clk, .a(ehv), .b(ci_d),   .y(t_e));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (.clk, .a(hv2), .b(drho_d), .y(a_e));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (.clk, .a(vme), .b(drho_d), .y(b_e));
  ctp_delay #(.WIDTH(W), .DEPTH(LM)) u_dly_dm (.clk, .d(dmud), .q(dmud_e));

  logic signed [W-1:0] dpin, s_f, t_f;
  always_ff @(posedge clk) begin
    dpin <= ctp_pkg::qadd(dmud_e, a_e);
    s_f  <= ctp_pkg::qadd(dmud_e, b_e);
    t_f  <= t_e;
  end

  logic signed [W-1:0] rho_f, p_m, dp_m, q_g, p_h, dp_h, dt_h, t_h;
  ctp_delay #(.WIDTH(W), .DEPTH(TF)) u_dly_rf (.clk, .d(density), .q(rho_f));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p  (.clk, .a(rr_f),  .b(t_f),  .y(p_m));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dp (.clk, .a(gm1_r), .b(dpin), .y(dp_m));
  ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_q  (.clk, .a(s_f),   .b(rho_f), .y(q_g));
  ctp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dt (.clk, .a(ci_g),  .b(q_g),  .y(dt_h));
  ctp_delay #(.WIDTH(2*W), .DEPTH(LD)) u_dly_p (
    .clk, .d({p_m, dp_m}), .q({p_h, dp_h})
  );
  ctp_delay #(.WIDTH(W), .DEPTH(LD + LM)) u_dly_t (.clk, .d(t_f), .q(t_h));

  logic signed [W-1:0] u_h, v_h, w_h;
  ctp_delay #(.WIDTH(3*W), .DEPTH(LD + 3*LM + 4)) u_dly_uvw (
    .clk, .d({u_a, v_a, w_a}), .q({u_h, v_h, w_h})
  );

  logic bad_h, last_h;
  ctp_delay #(.WIDTH(2), .DEPTH(TH)) u_dly_fl (
    .clk, .d({density <= 0, last_point}), .q({bad_h, last_h})
  );

  logic [TH-1:0] vline;
  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
      done  <= 1'b0;
    end else begin
      vline <= {vline[TH-2:0], start};
      done  <= vline[TH-1];
    end
  end

  // drop all values for a non-positive density
  always_ff @(posedge clk) begin
    pressure             <= bad_h ? '0 : p_h;
    velocity_x           <= bad_h ? '0 : u_h;
    velocity_y           <= bad_h ? '0 : v_h;
    velocity_z           <= bad_h ? '0 : w_h;
    temperature          <= bad_h ? '0 : t_h;
    pressure_gradient    <= bad_h ? '0 : dp_h;
    velocity_x_gradient  <= bad_h ? '0 : du_h;
    velocity_y_gradient  <= bad_h ? '0 : dv_h;
    velocity_z_gradient  <= bad_h ? '0 : dw_h;
    temperature_gradient <= bad_h ? '0 : dt_h;
    bad_density          <= bad_h;
    last_point_out       <= last_h;
  end

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT)) else $error("result without accepted beat");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    done |-> last_point_out == $past(last_point, LAT)) else $error("marker misaligned");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && bad_density |-> pressure == '0 && temperature == '0 &&
      temperature_gradient == '0 && velocity_x_gradient == '0)
    else $error("bad density result not zeroed");

endmodule

// ===== sv/ctp_delay.sv =====
// Fixed-length shift line for payload alignment.
module ctp_delay #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== sv/ctp_mul.sv =====
// Pipelined saturating fixed-point multiplier, rounded half away from zero.
module ctp_mul #(
  parameter int FRAC_BITS = ctp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic signed [ctp_pkg::WIDTH-1:0]   a,
  input  logic signed [ctp_pkg::WIDTH-1:0]   b,
  output logic signed [ctp_pkg::WIDTH-1:0]   y
);

  localparam int W  = ctp_pkg::WIDTH;
  localparam int H  = W / 2;
  localparam int PW = 2 * W;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

  logic [W-1:0]  mag_a, mag_b;
  logic          neg1, neg2, neg3;
  logic [W-1:0]  pp_ll, pp_lh, pp_hl, pp_hh;
  logic [PW-1:0] prod;
  logic [PW-1:0] res;

  assign res = prod >> FRAC_BITS;

  always_ff @(posedge clk) begin
    mag_a <= ctp_pkg::mag(a);
    mag_b <= ctp_pkg::mag(b);
    neg1  <= a[W-1] ^ b[W-1];
    // split into half-width partial products
    pp_ll <= mag_a[H-1:0] * mag_b[H-1:0];
    pp_lh <= mag_a[H-1:0] * mag_b[W-1:H];
    pp_hl <= mag_a[W-1:H] * mag_b[H-1:0];
    pp_hh <= mag_a[W-1:H] * mag_b[W-1:H];
    neg2  <= neg1;
    prod  <= (PW'(pp_hh) << W) + (PW'(pp_lh) << H) + (PW'(pp_hl) << H) + PW'(pp_ll) + RND;
    neg3  <= neg2;
    if (res > PW'(ctp_pkg::MAG_NEG_LIM)) begin
      y <= ctp_pkg::signed_result(ctp_pkg::MAG_NEG_LIM, neg3);
    end else begin
      y <= ctp_pkg::signed_result(res[W-1:0], neg3);
    end
  end

endmodule

// ===== sv/ctp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating, saturating.
module ctp_div #(
  parameter int FRAC_BITS = ctp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic signed [ctp_pkg::WIDTH-1:0] a,
  input  logic signed [ctp_pkg::WIDTH-1:0] b,
  output logic signed [ctp_pkg::WIDTH-1:0] y
);

  localparam int W  = ctp_pkg::WIDTH;
  localparam int NW = W + FRAC_BITS;

  logic [NW-1:0] numr [NW+1];
  logic [W-1:0]  rem  [NW+1];
  logic [W-1:0]  quo  [NW+1];
  logic [W-1:0]  den  [NW+1];
  logic          ovf  [NW+1];
  logic          neg  [NW+1];
  logic          zero [NW+1];

  always_ff @(posedge clk) begin
    numr[0] <= {ctp_pkg::mag(a), {FRAC_BITS{1'b0}}};
    rem[0]  <= '0;
    quo[0]  <= '0;
    den[0]  <= ctp_pkg::mag(b);
    ovf[0]  <= 1'b0;
    neg[0]  <= a[W-1] ^ b[W-1];
    // zero over zero gives zero; nonzero over zero saturates naturally
    zero[0] <= (a == '0);
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    localparam bit HIGH_BIT = (NW - 1 - k) >= W;
    logic [W:0] trial;
    logic       ge;

    assign trial = {rem[k], numr[k][NW-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      numr[k+1] <= numr[k] << 1;
      rem[k+1]  <= ge ? W'(trial - {1'b0, den[k]}) : W'(trial);
      quo[k+1]  <= {quo[k][W-2:0], ge};
      ovf[k+1]  <= ovf[k] | (ge & HIGH_BIT);
      den[k+1]  <= den[k];
      neg[k+1]  <= neg[k];
      zero[k+1] <= zero[k];
    end
  end

  always_ff @(posedge clk) begin
    if (zero[NW]) begin
      y <= '0;
    end else if (ovf[NW]) begin
      y <= ctp_pkg::signed_result(ctp_pkg::MAG_NEG_LIM, neg[NW]);
    end else begin
      y <= ctp_pkg::signed_result(quo[NW], neg[NW]);
    end
  end

endmodule

// ===== sv/ctp_cfg.sv =====
// APB register bank for gas constant and gamma minus one.
module ctp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ctp_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [ctp_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [ctp_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                              pready,
  output ctp_pkg::cfg_t                     cfg
);

  ctp_pkg::reg_index_t idx;

  assign idx    = ctp_pkg::reg_index_t'(paddr[3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gas_constant    <= ctp_pkg::GAS_CONSTANT_RST;
      cfg.gamma_minus_one <= ctp_pkg::GAMMA_MINUS_ONE_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        ctp_pkg::REG_GAS_CONSTANT:    cfg.gas_constant    <= pwdata[ctp_pkg::CFG_WIDTH-1:0];
        ctp_pkg::REG_GAMMA_MINUS_ONE: cfg.gamma_minus_one <= pwdata[ctp_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ctp_pkg::REG_GAS_CONSTANT:    prdata = 64'(cfg.gas_constant);
      ctp_pkg::REG_GAMMA_MINUS_ONE: prdata = 64'(cfg.gamma_minus_one);
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the ideal-gas conservative-to-primitive block.
`timescale 1ns / 1ps

module testbench;

  localparam int  FB       = ctp_pkg::FRAC_BITS_DEF;
  localparam longint QPOS  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint QNEG  = -64'sh0000_8000_0000_0000;
  localparam int  WD_LIMIT = 3000;
  localparam int  TAIL     = 200;

  typedef struct {
    longint f[10];
    bit     last;
  } cons_t;

  typedef struct {
    longint f[10];
    bit     bad;
    bit     last;
  } prim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ctp_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [ctp_pkg::DATA_WIDTH-1:0] pwdata = '0;
  logic [ctp_pkg::DATA_WIDTH-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [ctp_pkg::WIDTH-1:0] cin [10];
  logic last_point = 1'b0;
  logic done;
  logic signed [ctp_pkg::WIDTH-1:0] pout [10];
  logic bad_density, last_point_out;

  logic [ctp_pkg::CFG_WIDTH-1:0] r_gas = ctp_pkg::GAS_CONSTANT_RST;
  logic [ctp_pkg::CFG_WIDTH-1:0] r_gm1 = ctp_pkg::GAMMA_MINUS_ONE_RST;
  prim_t expected_prims[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    gaps_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cons_to_prim_with_gradients_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .density(cin[0]), .momentum_x(cin[1]), .momentum_y(cin[2]),
    .momentum_z(cin[3]), .total_energy(cin[4]), .density_gradient(cin[5]),
    .momentum_x_gradient(cin[6]), .momentum_y_gradient(cin[7]),
    .momentum_z_gradient(cin[8]), .energy_gradient(cin[9]),
    .last_point(last_point), .done(done),
    .pressure(pout[0]), .velocity_x(pout[1]), .velocity_y(pout[2]),
    .velocity_z(pout[3]), .temperature(pout[4]), .pressure_gradient(pout[5]),
    .velocity_x_gradient(pout[6]), .velocity_y_gradient(pout[7]),
    .velocity_z_gradient(pout[8]), .temperature_gradient(pout[9]),
    .bad_density(bad_density), .last_point_out(last_point_out)
  );

  // ---------------- fixed-point arithmetic ----------------
  function automatic logic [127:0] magnitude(longint a);
    return a < 0 ? 128'(-a) : 128'(a);
  endfunction

  function automatic longint apply_sign(logic [127:0] m, bit neg);
    logic [127:0] lim;
    lim = neg ? 128'(64'h8000_0000_0000) : 128'(64'h7FFF_FFFF_FFFF);
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_sat(longint x);
    return x > QPOS ? QPOS : (x < QNEG ? QNEG : x);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return fx_sat(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return fx_sat(a - b);
  endfunction

  // Round half away from zero on the magnitude.
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = magnitude(a) * magnitude(b);
    p = (p + (128'd1 << (FB - 1))) >> FB;
    return apply_sign(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [127:0] q;
    if (b == 0) return a > 0 ? QPOS : (a < 0 ? QNEG : 0);
    q = (magnitude(a) << FB) / magnitude(b);
    return apply_sign(q, (a < 0) != (b < 0));
  endfunction

  function automatic prim_t convert_point(cons_t c);
    prim_t  p;
    longint rho, u, v, w, e, ci, v2, hv2, t, ud, s, rg, gm;
    rho = c.f[0];
    rg  = longint'(r_gas);
    gm  = longint'(r_gm1);
    p.last = c.last;
    p.bad  = 1'b0;
    if (rho <= 0) begin
      for (int i = 0; i < 10; i++) p.f[i] = 0;
      p.bad = 1'b1;
      return p;
    end
    u   = fx_div(c.f[1], rho);
    v   = fx_div(c.f[2], rho);
    w   = fx_div(c.f[3], rho);
    e   = fx_div(c.f[4], rho);
    ci  = fx_div(gm, rg);
    v2  = fx_add(fx_add(fx_mul(u, u), fx_mul(v, v)), fx_mul(w, w));
    hv2 = v2 >>> 1;
    t   = fx_mul(fx_sub(e, hv2), ci);
    p.f[0] = fx_mul(fx_mul(rg, rho), t);
    p.f[1] = u;
    p.f[2] = v;
    p.f[3] = w;
    p.f[4] = t;
    ud = fx_add(fx_add(fx_mul(u, c.f[6]), fx_mul(v, c.f[7])), fx_mul(w, c.f[8]));
    p.f[5] = fx_mul(gm, fx_add(fx_sub(c.f[9], ud), fx_mul(hv2, c.f[5])));
    p.f[6] = fx_div(fx_sub(c.f[6], fx_mul(u, c.f[5])), rho);
    p.f[7] = fx_div(fx_sub(c.f[7], fx_mul(v, c.f[5])), rho);
    p.f[8] = fx_div(fx_sub(c.f[8], fx_mul(w, c.f[5])), rho);
    s = fx_add(fx_sub(c.f[9], ud), fx_mul(fx_sub(v2, e), c.f[5]));
    p.f[9] = fx_mul(ci, fx_div(s, rho));
    return p;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_point(cons_t c);
    bit ok;
    for (int i = 0; i < 10; i++) cin[i] <= c.f[i][ctp_pkg::WIDTH-1:0];
    last_point <= c.last;
    start <= 1'b1;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    expected_prims.push_back(convert_point(c));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (expected_prims.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(ctp_pkg::reg_index_t idx, logic [ctp_pkg::CFG_WIDTH-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ctp_pkg::ADDR_WIDTH'(8 * int'(idx));
    pwdata  <= ctp_pkg::DATA_WIDTH'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ctp_pkg::REG_GAS_CONSTANT) r_gas = val;
    else r_gm1 = val;
    @(posedge clk);
  endtask

  task automatic set_gas(logic [ctp_pkg::CFG_WIDTH-1:0] rg,
                         logic [ctp_pkg::CFG_WIDTH-1:0] gm);
    drain();
    write_reg(ctp_pkg::REG_GAS_CONSTANT, rg);
    write_reg(ctp_pkg::REG_GAMMA_MINUS_ONE, gm);
  endtask

  function automatic longint rand48();
    logic [ctp_pkg::WIDTH-1:0] x;
    x = ctp_pkg::WIDTH'({$urandom, $urandom});
    return longint'($signed(x));
  endfunction

  function automatic longint rand_small(int span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  // Physically plausible point with random content.
  function automatic cons_t gas_point();
    cons_t c;
    c.f[0] = longint'($urandom_range(1, 32'h0400_0000));
    for (int i = 1; i < 4; i++) c.f[i] = rand_small(32'h0800_0000);
    c.f[4] = longint'($urandom_range(0, 32'h1000_0000)) << $urandom_range(0, 3);
    for (int i = 5; i < 10; i++) c.f[i] = rand_small(32'h0400_0000);
    c.last = $urandom_range(0, 1);
    return c;
  endfunction

  function automatic cons_t noise_point();
    cons_t c;
    for (int i = 0; i < 10; i++) c.f[i] = rand48();
    c.last = $urandom_range(0, 1);
    return c;
  endfunction

  // ---------------- tests ----------------
  task automatic test_extremes;
    cons_t c;
    c = gas_point(); c.f[0] = 64'sd1 << FB;          send_point(c);
    c = gas_point(); c.f[0] = QPOS; c.last = 1;        send_point(c);
    c = gas_point(); c.f[0] = 1;                      send_point(c);
    c = gas_point(); c.f[0] = 0; c.last = 1;          send_point(c);
    c = gas_point(); c.f[0] = -1;                     send_point(c);
    c = gas_point(); c.f[0] = QNEG; c.last = 1;       send_point(c);
    for (int i = 0; i < 10; i++) c.f[i] = QPOS;
    c.last = 0;                                       send_point(c);
    for (int i = 1; i < 10; i++) c.f[i] = QNEG;
    c.last = 1;                                       send_point(c);
    c.f[0] = 1;                                       send_point(c);
    for (int i = 0; i < 10; i++) c.f[i] = 0;
    c.f[0] = 1;                                       send_point(c);
    c = gas_point(); c.f[0] = 64'sd1 << FB; c.f[4] = QNEG; send_point(c);
  endtask

  task automatic test_register_settings;
    set_gas(47'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF);
    repeat (6) send_point(gas_point());
    send_point(noise_point());
    set_gas(47'd1, 47'd1);
    repeat (6) send_point(gas_point());
    // gas constant of zero makes 1/cv a division by zero
    set_gas(47'd0, 47'd6710886);
    repeat (4) send_point(gas_point());
    set_gas(47'd0, 47'd0);
    repeat (2) send_point(gas_point());
  endtask

  task automatic test_random(int n, bit with_gaps);
    cons_t c;
    gaps_on = with_gaps;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        c = gas_point();
      end else begin
        c = noise_point();
        if ($urandom_range(0, 1) == 0) c.f[0] = -rand_small(32'h0100_0000) & 64'h7FFF;
      end
      send_point(c);
    end
  endtask

  task automatic test_config_sweep;
    logic [ctp_pkg::CFG_WIDTH-1:0] rg, gm;
    for (int k = 0; k < 4; k++) begin
      rg = ctp_pkg::CFG_WIDTH'($urandom_range(1, 32'h0800_0000));
      gm = ctp_pkg::CFG_WIDTH'($urandom_range(1, 32'h0200_0000));
      set_gas(rg, gm);
      test_random(40, 1'b1);
    end
    set_gas(47'd16777216, 47'd6710886);
  endtask

  // ---------------- checking ----------------
  always @(posedge clk) begin
    prim_t exp_p;
    if (!rst && done) begin
      if (expected_prims.size() == 0) begin
        $display("%0t: result with nothing pending", $time);
        errors++;
      end else begin
        exp_p = expected_prims.pop_front();
        for (int i = 0; i < 10; i++) begin
          if (longint'(pout[i]) !== exp_p.f[i]) begin
            $display("%0t: field %0d expected %0d actual %0d", $time, i,
                     exp_p.f[i], longint'(pout[i]));
            errors++;
          end
        end
        if (bad_density !== exp_p.bad) begin
          $display("%0t: bad_density expected %0b actual %0b", $time, exp_p.bad,
                   bad_density);
          errors++;
        end
        if (last_point_out !== exp_p.last) begin
          $display("%0t: last_point_out expected %0b actual %0b", $time, exp_p.last,
                   last_point_out);
          errors++;
        end
      end
    end
  end

  // Count cycles with no beat on either side.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 10; i++) cin[i] <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_register_settings();
    test_config_sweep();
    test_random(150, 1'b1);
    // hold the sender until every result is back
    drain();
    test_random(50, 1'b1);
    test_random(60, 1'b0);
    drain();
    repeat (TAIL) @(posedge clk);
    if (errors == 0 && expected_prims.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ctp_pkg.sv
sv/ctp_delay.sv
sv/ctp_mul.sv
sv/ctp_div.sv
sv/ctp_cfg.sv
sv/cons_to_prim_with_gradients_top.sv
tb/sv/testbench.sv
